/* design/id_bitmap_allocator_defines.svh */
// Assertion macros used by the id allocator top-level design file
`ifndef ID_BITMAP_ALLOCATOR_DEFINES_SVH
`define ID_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define IDBM_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define IDBM_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

/* design/idbm_pkg.sv */
// Package: opcodes, defaults and the first-clear-bit encoder of the id allocator
`timescale 1ns / 1ps

package idbm_pkg;

    localparam int MAP_BYTES_DEF = 32;
    localparam int ID_COUNT_DEF  = 256;

    localparam logic [7:0] TOP_BIT     = 8'h80;
    localparam logic [3:0] NO_CLEAR    = 4'd8;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_CLEAR   = 2'd2
    } idbm_op_t;

    // Position (from the MSB) of the most significant clear bit; NO_CLEAR if full
    function automatic logic [3:0] first_clear(input logic [7:0] v);
        logic [3:0] pos;
        pos = NO_CLEAR;
        for (int i = 7; i >= 0; i--)
        begin
            if (!v[i])
            begin
                pos = 4'(7 - i);
                break;
            end
        end
        return pos;
    endfunction

endpackage

/* design/id_bitmap_allocator.sv */
// Top level: first-free identifier allocator over a byte-wide usage bitmap
//
// Channel   Dir  Handshake                     Content
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: opcode; tdata: release_id
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: granted_id; tuser: none_free
//
// One transaction at a time; s_axis_tready is high only while the sequencer idles.
// Allocate: scans k map bytes (1..MAP_BYTES), one map byte per cycle
//   through the single read port of the bitmap memory and the shared encoder.
// Release: read, modify-write, result. Clear all: zero every map byte, then result.
// Unused opcode or out-of-range release: straight to the result.
// After reset a clearing pass writes zeros to every map byte; no input is taken.
// The result register holds a pending transaction while m_axis_tready is low; the
// sequencer waits in its result state until that register frees up.
`timescale 1ns / 1ps
`include "id_bitmap_allocator_defines.svh"

module id_bitmap_allocator
    import idbm_pkg::*;
#(
    parameter int MAP_BYTES = MAP_BYTES_DEF,
    parameter int ID_COUNT  = ID_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] release_id
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] granted_id
    output logic [0:0]  m_axis_tuser    // [0] none_free
);

    localparam int IDX_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int CNT_W = $clog2(MAP_BYTES + 1);
    localparam int ID_W  = IDX_W + 3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_REL_RD,
        S_REL_WR,
        S_DONE
    } state_t;

    // Bitmap memory, one byte per entry
    logic [7:0]       map_mem [MAP_BYTES];
    logic [7:0]       rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]       wr_data;

    state_t           state_reg,    state_next;
    logic [CNT_W-1:0] cnt_reg,      cnt_next;
    logic             pend_reg,     pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [7:0]       rid_reg,      rid_next;
    logic             clr_cmd_reg,  clr_cmd_next;
    logic [7:0]       res_id_reg,   res_id_next;
    logic             res_none_reg, res_none_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_id_reg,   out_id_next;
    logic             out_none_reg, out_none_next;

    logic [3:0]       clr_pos;
    logic [ID_W-1:0]  cand_id;
    logic             issue;
    logic             out_free;
    logic [IDX_W-1:0] rel_idx;
    logic             rel_ok;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_id_reg;
    assign m_axis_tuser  = out_none_reg;

    // Shared encoder on the byte just read
    assign clr_pos  = first_clear(rd_data_reg);
    assign cand_id  = {pend_idx_reg, clr_pos[2:0]};
    assign issue    = (cnt_reg < CNT_W'(MAP_BYTES));
    assign out_free = !out_valid_reg || m_axis_tready;
    assign rel_idx  = IDX_W'(rid_reg[7:3]);
    assign rel_ok   = (32'(s_axis_tdata) < 32'(ID_COUNT))
                   && (32'(s_axis_tdata[7:3]) < 32'(MAP_BYTES));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= map_mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        rid_next       = rid_reg;
        clr_cmd_next   = clr_cmd_reg;
        res_id_next    = res_id_reg;
        res_none_next  = res_none_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_id_next    = out_id_reg;
        out_none_next  = out_none_reg;
        rd_addr        = cnt_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = cnt_reg[IDX_W-1:0];
        wr_data        = 8'h00;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg[IDX_W-1:0] == IDX_W'(MAP_BYTES - 1))
                begin
                    res_id_next   = 8'h00;
                    res_none_next = 1'b0;
                    state_next    = clr_cmd_reg ? S_DONE : S_IDLE;
                    clr_cmd_next  = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    rid_next      = s_axis_tdata;
                    cnt_next      = '0;
                    res_id_next   = 8'h00;
                    res_none_next = 1'b0;
                    case (s_axis_tuser)
                        OP_ALLOC:   state_next = S_SCAN;
                        OP_RELEASE: state_next = rel_ok ? S_REL_RD : S_DONE;
                        OP_CLEAR:
                        begin
                            clr_cmd_next = 1'b1;
                            state_next   = S_CLEAR;
                        end
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN:
            begin
                // read of byte cnt overlaps the check of the byte read last cycle
                pend_next     = issue;
                pend_idx_next = cnt_reg[IDX_W-1:0];
                cnt_next      = cnt_reg + CNT_W'(issue);
                if (pend_reg)
                begin
                    if (clr_pos != NO_CLEAR)
                    begin
                        pend_next  = 1'b0;
                        state_next = S_DONE;
                        if (32'(cand_id) < 32'(ID_COUNT))
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = pend_idx_reg;
                            wr_data     = rd_data_reg | (TOP_BIT >> clr_pos[2:0]);
                            res_id_next = 8'(cand_id);
                        end
                        else
                        begin
                            res_none_next = 1'b1;
                        end
                    end
                    else if (pend_idx_reg == IDX_W'(MAP_BYTES - 1))
                    begin
                        pend_next     = 1'b0;
                        res_none_next = 1'b1;
                        state_next    = S_DONE;
                    end
                end
            end
            S_REL_RD:
            begin
                rd_addr    = rel_idx;
                state_next = S_REL_WR;
            end
            S_REL_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = rel_idx;
                wr_data    = rd_data_reg & ~(TOP_BIT >> rid_reg[2:0]);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = res_id_reg;
                    out_none_next  = res_none_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            clr_cmd_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_id_reg    <= 8'h00;
            out_none_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            clr_cmd_reg   <= clr_cmd_next;
            out_valid_reg <= out_valid_next;
            out_id_reg    <= out_id_next;
            out_none_reg  <= out_none_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        rid_reg      <= rid_next;
        res_id_reg   <= res_id_next;
        res_none_reg <= res_none_next;
    end

    `IDBM_ASSERT_NOW(a_none_free_zero_id, m_axis_tvalid && m_axis_tuser[0],
        m_axis_tdata == 8'h00, "none_free result carries a non-zero id")
    `IDBM_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "input taken again straight after a transaction")
    `IDBM_ASSERT_NEXT(a_result_from_done, state_reg == S_DONE && out_free,
        m_axis_tvalid && state_reg == S_IDLE, "result not issued from done state")
    `IDBM_ASSERT_NOW(a_scan_in_range, state_reg == S_SCAN,
        cnt_reg <= CNT_W'(MAP_BYTES), "scan pointer ran past the map")

endmodule

/* tb/id_bitmap_allocator_tb.sv */
// Testbench for id_bitmap_allocator: random allocate/release/clear traffic scored against a bitmap model
`timescale 1ns / 1ps

module id_bitmap_allocator_tb;
    import idbm_pkg::*;

    // The fourth opcode has no package name; the block must treat it as a no-op
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS = 1050;
    localparam int         STALL_LIMIT  = 2000;   // cycles with no transaction on either side
    localparam int         DRAIN_CYCLES = 80;     // settling time once every owed result is in

    typedef struct packed {
        logic [7:0] granted_id;
        logic       none_free;
    } grant_t;

    typedef enum int {
        FILL_PHASE,
        MIXED_PHASE,
        DRAIN_PHASE
    } phase_t;

    // Shadow copy of the usage bitmap plus the queue of grants still owed by the block
    class id_map_tracker;
        logic [7:0] used_bytes [MAP_BYTES_DEF];
        grant_t     pending_grants [$];
        int         failures;

        function new();
            foreach (used_bytes[i])
                used_bytes[i] = 8'h00;
            failures = 0;
        endfunction

        function int outstanding();
            return pending_grants.size();
        endfunction

        // Apply one accepted request to the shadow map and queue its result
        function void note_request(logic [1:0] op, logic [7:0] rid);
            grant_t g;
            int     pos;
            int     id;
            g.granted_id = 8'h00;
            g.none_free  = 1'b0;
            case (op)
                OP_ALLOC:
                begin
                    g.none_free = 1'b1;
                    for (int b = 0; b < MAP_BYTES_DEF; b++)
                    begin
                        if (used_bytes[b] != 8'hFF)
                        begin
                            // MSB of the byte is the lowest id
                            pos = 0;
                            while (used_bytes[b][7 - pos])
                                pos++;
                            id = b * 8 + pos;
                            if (id < ID_COUNT_DEF)
                            begin
                                used_bytes[b][7 - pos] = 1'b1;
                                g.granted_id = 8'(id);
                                g.none_free  = 1'b0;
                            end
                            break;
                        end
                    end
                end
                OP_RELEASE:
                begin
                    // out-of-range ids are dropped silently
                    if (rid < ID_COUNT_DEF && (rid >> 3) < MAP_BYTES_DEF)
                        used_bytes[rid >> 3][7 - rid[2:0]] = 1'b0;
                end
                OP_CLEAR:
                begin
                    foreach (used_bytes[i])
                        used_bytes[i] = 8'h00;
                end
                default:
                begin
                end
            endcase
            pending_grants.push_back(g);
        endfunction

        // Compare one delivered result against the oldest outstanding grant
        function void check_grant(logic [7:0] gid, logic nf);
            grant_t exp_g;
            if (pending_grants.size() == 0)
            begin
                $error("result with nothing outstanding: granted_id %0d none_free %0b", gid, nf);
                failures++;
                return;
            end
            exp_g = pending_grants.pop_front();
            if (gid !== exp_g.granted_id)
            begin
                $error("granted_id: expected %0d, actual %0d", exp_g.granted_id, gid);
                failures++;
            end
            if (nf !== exp_g.none_free)
            begin
                $error("none_free: expected %0b, actual %0b", exp_g.none_free, nf);
                failures++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;    // [7:0] release_id
    logic [1:0] s_axis_tuser;    // [1:0] opcode
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;    // [7:0] granted_id
    logic [0:0] m_axis_tuser;    // [0] none_free

    id_map_tracker tracker = new();
    int            items_sent;

    id_bitmap_allocator dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Both channels are observed in one process so a request is always noted
    // before any result from the same edge is checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                tracker.note_request(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_grant(m_axis_tdata, m_axis_tuser[0]);
        end
    end

    // Watchdog: abort when neither channel moves for too long
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result-side backpressure: short flickers, long clear runs and the odd long stall
    initial
    begin
        int pick;
        int hi_len;
        int lo_len;
        m_axis_tready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
            begin
                hi_len = $urandom_range(1, 8);
                lo_len = $urandom_range(1, 3);
            end
            else if (pick < 8)
            begin
                hi_len = $urandom_range(20, 200);
                lo_len = 1;
            end
            else
            begin
                hi_len = $urandom_range(1, 4);
                lo_len = $urandom_range(10, 60);
            end
            m_axis_tready <= 1'b1;
            repeat (hi_len) @(posedge clk);
            m_axis_tready <= 1'b0;
            repeat (lo_len) @(posedge clk);
        end
    end

    // Mostly back-to-back, sometimes a few cycles, occasionally a long gap
    function automatic int rand_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 40);
    endfunction

    function automatic logic [1:0] pick_op(phase_t phase);
        int pick;
        pick = $urandom_range(0, 99);
        case (phase)
            FILL_PHASE:
            begin
                if (pick < 95)
                    return OP_ALLOC;
                else if (pick < 99)
                    return OP_RELEASE;
                else
                    return OP_UNUSED;
            end
            MIXED_PHASE:
            begin
                if (pick < 45)
                    return OP_ALLOC;
                else if (pick < 87)
                    return OP_RELEASE;
                else if (pick < 97)
                    return OP_UNUSED;
                else
                    return OP_CLEAR;
            end
            default:
            begin
                if (pick < 15)
                    return OP_ALLOC;
                else if (pick < 95)
                    return OP_RELEASE;
                else if (pick < 98)
                    return OP_UNUSED;
                else
                    return OP_CLEAR;
            end
        endcase
    endfunction

    // Low ids fill first, so half the releases aim there to hit live entries
    function automatic logic [7:0] pick_release_id();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, 255));
        else
            return 8'($urandom_range(0, 47));
    endfunction

    // Present one request and hold it until accepted; valid stays high when gap is 0
    task automatic send_item(input logic [1:0] op, input logic [7:0] rid, input int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= rid;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // Hold off the request side until every owed result has been delivered
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.outstanding() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        phase_t     phase;
        int         seg_len;
        int         random_base;
        bit         burst;
        logic [1:0] op;
        logic [7:0] rid;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = OP_ALLOC;
        items_sent    = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: first grants, hole refill, double release, top id,
        // unused opcode, clear-all
        send_item(OP_ALLOC,   8'h00, 0);
        send_item(OP_ALLOC,   8'hFF, 0);
        send_item(OP_ALLOC,   8'h00, rand_gap());
        send_item(OP_RELEASE, 8'd1,  rand_gap());
        send_item(OP_ALLOC,   8'h00, 0);
        send_item(OP_RELEASE, 8'd1,  0);
        send_item(OP_RELEASE, 8'd1,  rand_gap());
        send_item(OP_RELEASE, 8'd255, 0);
        send_item(OP_RELEASE, 8'hAA, 0);
        send_item(OP_UNUSED,  8'hFF, rand_gap());
        send_item(OP_ALLOC,   8'hFF, 0);
        send_item(OP_CLEAR,   8'h55, 0);
        send_item(OP_ALLOC,   8'h00, rand_gap());
        send_item(OP_RELEASE, 8'd0,  0);
        send_item(OP_ALLOC,   8'h00, 0);
        wait_drained();

        // Random: first phase is allocate-heavy and long enough to fill the map,
        // so the top id and the map-full response are both reached
        random_base = items_sent;
        phase       = FILL_PHASE;
        seg_len     = 300;
        while (items_sent - random_base < RANDOM_ITEMS)
        begin
            burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < seg_len && items_sent - random_base < RANDOM_ITEMS; i++)
            begin
                op  = pick_op(phase);
                rid = (op == OP_RELEASE) ? pick_release_id() : 8'($urandom_range(0, 255));
                send_item(op, rid, burst ? 0 : rand_gap());
            end
            if ($urandom_range(0, 3) == 0)
                wait_drained();
            phase   = phase_t'($urandom_range(0, 2));
            seg_len = $urandom_range(20, 150);
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* id_bitmap_allocator.f */
+incdir+design
design/idbm_pkg.sv
design/id_bitmap_allocator.sv
tb/id_bitmap_allocator_tb.sv
